// ----- design/hpd_pkg.sv -----
`default_nettype none

package hpd_pkg;

    localparam int unsigned PAL_DEPTH  = 64;
    localparam int unsigned PAL_AW     = 6;
    localparam int unsigned RGB_W      = 24;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned COMP_W     = 8;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Same two-bit coding in HAM6 (code 5:4) and HAM8 (code 7:6)
    typedef enum logic [1:0] {
        OP_PAL   = 2'd0,
        OP_BLUE  = 2'd1,
        OP_RED   = 2'd2,
        OP_GREEN = 2'd3
    } op_t;

    typedef struct packed {
        logic               is_pixel;
        op_t                op;
        logic [PAL_AW-1:0]  idx;
        logic [COMP_W-1:0]  comp;
        logic [RGB_W-1:0]   color;
        logic               row_start;
    } entry_t;

endpackage

`default_nettype wire

// ----- design/ham_pixel_decoder.sv -----
// Channel   | Handshake              | Payload
// ----------+------------------------+-----------------------------------------------
// item in   | item_valid, item_stall | mode, pal_index, pal_color, pixel_code, row_start
// rgb out   | rgb_valid, rgb_stall   | rgb_out
// config    | cfg_we                 | cfg_wdata (ham8_mode)
//
// One item per cycle sustained while rgb_stall is low; a pixel taken in goes through the
// 2-entry queue, the registered palette RAM read and the output register before rgb_out.
// Palette loads give no result; the RAM is written at the edge a load leaves the queue.
// rst_n clears the mode, held color and palette valid bits at once; no clearing pass.
// A stalled output holds one result; the queue then fills and raises item_stall.
`default_nettype none

module ham_pixel_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        mode,
    input  wire logic [5:0]  pal_index,
    input  wire logic [23:0] pal_color,
    input  wire logic [7:0]  pixel_code,
    input  wire logic        row_start,
    output logic             rgb_valid,
    input  wire logic        rgb_stall,
    output logic [23:0]      rgb_out
);

    import hpd_pkg::*;

    entry_t front_entry;
    entry_t q_head;
    logic   push;
    logic   q_full;
    logic   q_not_empty;
    logic   q_pop;

    hpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .mode       (mode),
        .pal_index  (pal_index),
        .pal_color  (pal_color),
        .pixel_code (pixel_code),
        .row_start  (row_start),
        .queue_full (q_full),
        .push       (push),
        .entry      (front_entry)
    );

    hpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    hpd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .rgb_valid   (rgb_valid),
        .rgb_stall   (rgb_stall),
        .rgb_out     (rgb_out)
    );

endmodule

`default_nettype wire

// ----- design/hpd_ram.sv -----
`default_nettype none

module hpd_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/hpd_front.sv -----
`default_nettype none

module hpd_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_wdata,
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire logic                      mode,
    input  wire logic [5:0]                pal_index,
    input  wire logic [23:0]               pal_color,
    input  wire logic [7:0]                pixel_code,
    input  wire logic                      row_start,
    input  wire logic                      queue_full,
    output logic                           push,
    output hpd_pkg::entry_t                entry
);

    import hpd_pkg::*;

    logic ham8_reg;
    logic ham8_next;

    always_comb
    begin
        ham8_next = cfg_we ? cfg_wdata : ham8_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ham8_reg <= 1'b0;
        end
        else
        begin
            ham8_reg <= ham8_next;
        end
    end

    assign item_stall = queue_full;
    assign push       = item_valid && !queue_full;

    // Classify: pick op, palette index and expanded component value
    always_comb
    begin
        entry.is_pixel  = mode;
        entry.color     = pal_color;
        entry.row_start = row_start;
        if (!mode)
        begin
            entry.op   = OP_PAL;
            entry.idx  = pal_index;
            entry.comp = '0;
        end
        else if (ham8_reg)
        begin
            entry.op   = op_t'(pixel_code[7:6]);
            entry.idx  = pixel_code[5:0];
            entry.comp = {pixel_code[5:0], pixel_code[5:4]};
        end
        else
        begin
            entry.op   = op_t'(pixel_code[5:4]);
            entry.idx  = {2'b00, pixel_code[3:0]};
            entry.comp = {pixel_code[3:0], pixel_code[3:0]};
        end
    end

endmodule

`default_nettype wire

// ----- design/hpd_queue.sv -----
`default_nettype none

module hpd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire hpd_pkg::entry_t push_entry,
    input  wire logic            pop,
    output logic                 full,
    output logic                 not_empty,
    output hpd_pkg::entry_t      head
);

    import hpd_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    entry_t          slots_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [PW:0]     count_reg;
    logic [PW:0]     count_next;

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- design/hpd_back.sv -----
`default_nettype none

module hpd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_not_empty,
    input  wire hpd_pkg::entry_t q_head,
    output logic                 q_pop,
    output logic                 rgb_valid,
    input  wire logic            rgb_stall,
    output logic [23:0]          rgb_out
);

    import hpd_pkg::*;

    logic [PAL_DEPTH-1:0] pal_valid_reg;
    logic [PAL_DEPTH-1:0] pal_valid_next;
    logic [RGB_W-1:0]     entry0_reg;
    logic [RGB_W-1:0]     entry0_next;
    logic [RGB_W-1:0]     held_reg;
    logic [RGB_W-1:0]     held_next;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    op_t                  s1_op_reg;
    logic [COMP_W-1:0]    s1_comp_reg;
    logic                 s1_row_reg;
    logic [RGB_W-1:0]     s1_entry0_reg;
    logic                 s1_hit_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [RGB_W-1:0]     out_data_reg;
    logic [RGB_W-1:0]     ram_rdata;
    logic [RGB_W-1:0]     base;
    logic [RGB_W-1:0]     pal_word;
    logic [RGB_W-1:0]     result;
    logic                 s1_move;
    logic                 s1_ready;
    logic                 pop_write;
    logic                 pop_pixel;

    assign s1_move   = s1_valid_reg && (!out_valid_reg || !rgb_stall);
    assign s1_ready  = !s1_valid_reg || s1_move;
    // Palette writes never wait; a pixel waits until stage 1 frees up
    assign q_pop     = q_not_empty && (!q_head.is_pixel || s1_ready);
    assign pop_write = q_pop && !q_head.is_pixel;
    assign pop_pixel = q_pop && q_head.is_pixel;

    hpd_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PAL_DEPTH)
    ) u_pal (
        .clk   (clk),
        .we    (pop_write),
        .waddr (q_head.idx),
        .wdata (q_head.color),
        .re    (pop_pixel),
        .raddr (q_head.idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pal_valid_next = pal_valid_reg;
        entry0_next    = entry0_reg;
        if (pop_write)
        begin
            pal_valid_next[q_head.idx] = 1'b1;
            if (q_head.idx == '0)
            begin
                entry0_next = q_head.color;
            end
        end
    end

    // Stage 1: RAM data is in; take the palette word or modify the held color (entry 0 at row start)
    always_comb
    begin
        base     = s1_row_reg ? s1_entry0_reg : held_reg;
        pal_word = s1_hit_reg ? ram_rdata : '0;
        unique case (s1_op_reg)
            OP_PAL:   result = pal_word;
            OP_BLUE:  result = {base[23:8], s1_comp_reg};
            OP_RED:   result = {s1_comp_reg, base[15:0]};
            OP_GREEN: result = {base[23:16], s1_comp_reg, base[7:0]};
            default:  result = pal_word;
        endcase
    end

    always_comb
    begin
        held_next      = s1_move ? result : held_reg;
        s1_valid_next  = pop_pixel ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_move ? 1'b1 : (out_valid_reg && rgb_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= '0;
            entry0_reg    <= '0;
            held_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pal_valid_reg <= pal_valid_next;
            entry0_reg    <= entry0_next;
            held_reg      <= held_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_pixel)
        begin
            s1_op_reg     <= q_head.op;
            s1_comp_reg   <= q_head.comp;
            s1_row_reg    <= q_head.row_start;
            s1_entry0_reg <= entry0_reg;
            s1_hit_reg    <= pal_valid_reg[q_head.idx];
        end
        if (s1_move)
        begin
            out_data_reg <= result;
        end
    end

    assign rgb_valid = out_valid_reg;
    assign rgb_out   = out_data_reg;

    a_pixel_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
        pop_pixel |=> s1_valid_reg)
        else $error("popped pixel did not reach stage 1");

    a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_move |=> $stable(held_reg))
        else $error("held color changed without a pixel finishing");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg)
        else $error("stalled stage 1 pixel dropped");

    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rgb_stall && !s1_move |=> !out_valid_reg)
        else $error("taken result shown again");

endmodule

`default_nettype wire
